// ----- design/sv39_page_table_mapper_defines.svh -----
// assertion helpers used by the checker file
`ifndef SV39_PAGE_TABLE_MAPPER_DEFINES_SVH
`define SV39_PAGE_TABLE_MAPPER_DEFINES_SVH

// same-cycle implication
`define SV39PTM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SV39PTM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/sv39ptm_pkg.sv -----
package sv39ptm_pkg;

   localparam int VPN_W   = 27;
   localparam int PPN_W   = 44;
   localparam int PROT_W  = 8;
   localparam int IDX_W   = 9;
   localparam int ENTRY_W = 54;
   localparam int NEW_W   = 2;

   // valid, read, write, execute, user, accessed, dirty
   localparam logic [PROT_W-1:0] LEAF_FLAGS = 8'hdf;
   localparam logic [PPN_W-1:0]  POOL_BASE_RESET = 44'd524288;

   typedef logic [VPN_W-1:0]   vpn_type;
   typedef logic [PPN_W-1:0]   ppn_type;
   typedef logic [PROT_W-1:0]  prot_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [ENTRY_W-1:0] entry_type;
   typedef logic [NEW_W-1:0]   new_type;

   // live: entry was written while its page was already allocated
   typedef struct packed {
      logic      live;
      entry_type entry;
   } mem_word_type;

endpackage

// ----- design/sv39_page_table_mapper.sv -----
// Sv39 page-table mapper: each req item installs one mapping (virtual page ->
// physical page with extra protection bits) in a three-level Sv39 table tree
// held in an on-block store of TABLE_PAGES pages of 512 entries; pool page 0
// is the root and fresh table pages come from a bump allocator, pointer
// entries carrying pool_base_page + page. One rsp item follows each req item:
// status 0 with the leaf entry written and the number of table pages taken,
// or status 1 (store untouched) when the pool would run out or a pointer
// lands outside the pool. Items are handled one at a time through the single
// table memory (one read and one write per cycle, registered read): after
// acceptance the walk reads the root entry, then the middle entry unless a
// fresh middle page is taken (which skips the middle read), writes the
// pointer entries for any fresh table pages and then the leaf, and registers
// the rsp item; an error is registered straight from the root or middle
// read. The rsp register then holds until taken, and the next item is
// accepted only after that, back in idle. After reset the store is swept to
// zero, one entry per cycle, and req_stall stays high until the sweep ends;
// csr writes are accepted at any time, but are meant only for an idle block.
module sv39_page_table_mapper #(
   parameter int TABLE_PAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sv39ptm_pkg::vpn_type  req_virt_page,
   input  sv39ptm_pkg::ppn_type  req_phys_page,
   input  sv39ptm_pkg::prot_type req_prot_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_status,
   output sv39ptm_pkg::entry_type rsp_leaf_entry,
   output sv39ptm_pkg::new_type  rsp_new_tables,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  sv39ptm_pkg::ppn_type  csr_data
);
   import sv39ptm_pkg::*;

   localparam int PAGE_W = $clog2(TABLE_PAGES);
   localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);
   localparam int ADDR_W = PAGE_W + IDX_W;
   localparam int NF_W   = $clog2(TABLE_PAGES + 1);

   // sequencer codes
   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_ROOT    = 3'd2;
   localparam logic [2:0] ST_MID     = 3'd3;
   localparam logic [2:0] ST_WR_ROOT = 3'd4;
   localparam logic [2:0] ST_WR_MID  = 3'd5;
   localparam logic [2:0] ST_WR_LEAF = 3'd6;
   localparam logic [2:0] ST_RESP    = 3'd7;

   // table store, read data registered
   mem_word_type table_mem [DEPTH];

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [NF_W-1:0]   next_free_ff, next_free_in;
   ppn_type           pool_base_ff, pool_base_in;
   vpn_type           vpn_ff, vpn_in;
   ppn_type           ppn_ff, ppn_in;
   prot_type          prot_ff, prot_in;
   logic [PAGE_W-1:0] mid_page_ff, mid_page_in;
   logic [PAGE_W-1:0] leaf_page_ff, leaf_page_in;
   new_type           needed_ff, needed_in;
   mem_word_type      rd_word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   entry_type         rsp_leaf_ff, rsp_leaf_in;
   new_type           rsp_new_ff, rsp_new_in;

   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   mem_word_type      wr_word;

   // decoded view of the word just read
   ppn_type           rd_rel;
   logic              rd_in_pool;
   logic [PAGE_W-1:0] rd_page;
   logic              root_ok;
   logic              mid_ok;
   logic              mid_alloc;
   logic              leaf_alloc;
   logic              fits_one;
   logic              fits_two;
   entry_type         ptr_entry;
   entry_type         leaf_val;

   idx_type idx_root, idx_mid, idx_leaf;

   assign idx_root = vpn_ff[3*IDX_W-1:2*IDX_W];
   assign idx_mid  = vpn_ff[2*IDX_W-1:IDX_W];
   assign idx_leaf = vpn_ff[IDX_W-1:0];

   // pointer target relative to the pool, wraps mod 2^44
   assign rd_rel     = rd_word_ff.entry[ENTRY_W-1:10] - pool_base_ff;
   assign rd_in_pool = rd_rel < ppn_type'(TABLE_PAGES);
   assign rd_page    = rd_rel[PAGE_W-1:0];

   // page allocated => entries written before allocation read as zero
   assign mid_alloc  = NF_W'(mid_page_ff) < next_free_ff;
   assign leaf_alloc = NF_W'(leaf_page_ff) < next_free_ff;
   assign root_ok    = rd_word_ff.entry[0] && rd_word_ff.live;
   assign mid_ok     = rd_word_ff.entry[0] && (rd_word_ff.live || !mid_alloc);

   assign fits_one = ({1'b0, next_free_ff} + (NF_W+1)'(1)) <= (NF_W+1)'(TABLE_PAGES);
   assign fits_two = ({1'b0, next_free_ff} + (NF_W+1)'(2)) <= (NF_W+1)'(TABLE_PAGES);

   assign ptr_entry = {pool_base_ff + PPN_W'(next_free_ff), 9'd0, 1'b1};
   assign leaf_val  = {ppn_ff, 2'b00, prot_ff | LEAF_FLAGS};

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      next_free_in  = next_free_ff;
      pool_base_in  = pool_base_ff;
      vpn_in        = vpn_ff;
      ppn_in        = ppn_ff;
      prot_in       = prot_ff;
      mid_page_in   = mid_page_ff;
      leaf_page_in  = leaf_page_ff;
      needed_in     = needed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_leaf_in   = rsp_leaf_ff;
      rsp_new_in    = rsp_new_ff;
      rd_addr       = {PAGE_W'(0), req_virt_page[3*IDX_W-1:2*IDX_W]};
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_word       = '0;

      if (csr_valid) begin
         pool_base_in = csr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               vpn_in   = req_virt_page;
               ppn_in   = req_phys_page;
               prot_in  = req_prot_bits;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            // root page is always allocated
            rd_addr = {rd_page, idx_mid};
            if (!root_ok) begin
               needed_in = 2'd2;
               mid_page_in = '0;
               if (fits_two) begin
                  state_in = ST_WR_ROOT;
               end else begin
                  rsp_status_in = 1'b1;
                  rsp_leaf_in   = '0;
                  rsp_new_in    = '0;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_RESP;
               end
            end else if (!rd_in_pool) begin
               rsp_status_in = 1'b1;
               rsp_leaf_in   = '0;
               rsp_new_in    = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_RESP;
            end else begin
               mid_page_in = rd_page;
               state_in    = ST_MID;
            end
         end
         ST_MID: begin
            if (!mid_ok) begin
               needed_in = 2'd1;
               if (fits_one) begin
                  state_in = ST_WR_MID;
               end else begin
                  rsp_status_in = 1'b1;
                  rsp_leaf_in   = '0;
                  rsp_new_in    = '0;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_RESP;
               end
            end else if (!rd_in_pool) begin
               rsp_status_in = 1'b1;
               rsp_leaf_in   = '0;
               rsp_new_in    = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_RESP;
            end else begin
               needed_in    = 2'd0;
               leaf_page_in = rd_page;
               state_in     = ST_WR_LEAF;
            end
         end
         ST_WR_ROOT: begin
            wr_en         = 1'b1;
            wr_addr       = {PAGE_W'(0), idx_root};
            wr_word.live  = 1'b1;
            wr_word.entry = ptr_entry;
            mid_page_in   = next_free_ff[PAGE_W-1:0];
            next_free_in  = next_free_ff + NF_W'(1);
            state_in      = ST_WR_MID;
         end
         ST_WR_MID: begin
            wr_en         = 1'b1;
            wr_addr       = {mid_page_ff, idx_mid};
            // the leaf page taken here may be this very page, cleared first
            wr_word.live  = NF_W'(mid_page_ff) <= next_free_ff;
            wr_word.entry = ptr_entry;
            leaf_page_in  = next_free_ff[PAGE_W-1:0];
            next_free_in  = next_free_ff + NF_W'(1);
            state_in      = ST_WR_LEAF;
         end
         ST_WR_LEAF: begin
            wr_en         = 1'b1;
            wr_addr       = {leaf_page_ff, idx_leaf};
            wr_word.live  = leaf_alloc;
            wr_word.entry = leaf_val;
            rsp_status_in = 1'b0;
            rsp_leaf_in   = leaf_val;
            rsp_new_in    = needed_ff;
            rsp_valid_in  = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         next_free_ff <= NF_W'(1);
         pool_base_ff <= POOL_BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         next_free_ff <= next_free_in;
         pool_base_ff <= pool_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vpn_ff        <= vpn_in;
      ppn_ff        <= ppn_in;
      prot_ff       <= prot_in;
      mid_page_ff   <= mid_page_in;
      leaf_page_ff  <= leaf_page_in;
      needed_ff     <= needed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_leaf_ff   <= rsp_leaf_in;
      rsp_new_ff    <= rsp_new_in;
   end

   // memory ports
   always_ff @(posedge clock) begin
      rd_word_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_word;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_leaf_entry = rsp_leaf_ff;
   assign rsp_new_tables = rsp_new_ff;

endmodule

// ----- design/sv39ptm_checker.sv -----
`include "sv39_page_table_mapper_defines.svh"

module sv39ptm_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_status,
   input sv39ptm_pkg::entry_type rsp_leaf_entry,
   input sv39ptm_pkg::new_type   rsp_new_tables
);
   import sv39ptm_pkg::*;

   // a stalled rsp item holds
   `SV39PTM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_leaf_entry) && $stable(rsp_new_tables), "rsp item changed while stalled")

   // an error leaves the payload clear
   `SV39PTM_ASSERT_IMP(a_err_clear, clock, reset, rsp_valid && rsp_status, rsp_leaf_entry == '0 && rsp_new_tables == '0, "error rsp carries data")

   // an installed leaf always has its flag bits
   `SV39PTM_ASSERT_IMP(a_leaf_flags, clock, reset, rsp_valid && !rsp_status, (rsp_leaf_entry[7:0] & LEAF_FLAGS) == LEAF_FLAGS && rsp_new_tables != 2'd3, "leaf entry missing flags")

   // the walk takes time: no rsp right after an accepted item
   `SV39PTM_ASSERT_NXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall, !rsp_valid, "rsp too early after accept")

endmodule

bind sv39_page_table_mapper sv39ptm_checker u_sv39ptm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_leaf_entry (rsp_leaf_entry),
   .rsp_new_tables (rsp_new_tables)
);

// ----- bench/testbench.sv -----
module testbench;
   import sv39ptm_pkg::*;

   localparam int POOL_PAGES   = 16;
   localparam int PAGE_ENTRIES = 512;
   localparam int SLOT_W       = $clog2(POOL_PAGES*PAGE_ENTRIES);
   // long enough for the store sweep after reset plus the longest stall
   localparam int IDLE_LIMIT   = 40000;

   // response status codes
   localparam logic MAP_DONE    = 1'b0;
   localparam logic MAP_REFUSED = 1'b1;

   // pool base settings visited besides the reset value
   localparam ppn_type BASE_LOWEST  = '0;
   localparam ppn_type BASE_HIGHEST = '1;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      vpn_type  vpn;
      ppn_type  ppn;
      prot_type prot;
   } map_request_type;

   typedef struct packed {
      logic      status;
      entry_type leaf;
      new_type   tables;
   } map_outcome_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   vpn_type   req_virt_page = '0;
   ppn_type   req_phys_page = '0;
   prot_type  req_prot_bits = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_status;
   entry_type rsp_leaf_entry;
   new_type   rsp_new_tables;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   ppn_type   csr_data = POOL_BASE_RESET;

   sv39_page_table_mapper #(
      .TABLE_PAGES(POOL_PAGES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_virt_page  (req_virt_page),
      .req_phys_page  (req_phys_page),
      .req_prot_bits  (req_prot_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_leaf_entry (rsp_leaf_entry),
      .rsp_new_tables (rsp_new_tables),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow of the table tree: pool pages, bump pointer and pool base
   // ---------------------------------------------------------------------
   entry_type   shadow_tables [POOL_PAGES*PAGE_ENTRIES] = '{default: '0};
   int unsigned next_table = 1;     // page 0 is the root
   ppn_type     pool_base = POOL_BASE_RESET;

   // expected responses in order of acceptance
   map_outcome_type outstanding [$];
   // items waiting to be driven
   map_request_type pending [$];

   int mismatches    = 0;
   int requests_sent = 0;
   int responses     = 0;
   int installed     = 0;
   int tables_taken  = 0;
   int base_settings = 1;

   // shadow slot of one entry of a pool page
   function automatic slot_type slot_of(int unsigned page, idx_type idx);
      return slot_type'(page*PAGE_ENTRIES + int'(idx));
   endfunction

   // pool page that a pointer entry refers to, POOL_PAGES when it lies outside
   function automatic int unsigned pool_page(entry_type pte);
      ppn_type rel;
      rel = pte[ENTRY_W-1:10] - pool_base;   // wraps at 44 bits
      return (rel < POOL_PAGES) ? int'(rel) : POOL_PAGES;
   endfunction

   // pointer entry towards a pool page, base plus page wrapping at 44 bits
   function automatic entry_type pointer_to(int unsigned page);
      ppn_type target;
      target = pool_base + ppn_type'(page);
      return {target, 10'd0} | entry_type'(1);
   endfunction

   // bump allocation: a fresh page always starts out zeroed
   function automatic int unsigned take_table();
      int unsigned page;
      page = next_table;
      next_table++;
      for (int e = 0; e < PAGE_ENTRIES; e++) shadow_tables[slot_of(page, idx_type'(e))] = '0;
      return page;
   endfunction

   // walk root, middle and leaf level and install the mapping; refusals
   // leave the shadow untouched, so the walk is checked before anything moves
   function automatic map_outcome_type install_mapping(vpn_type vpn, ppn_type ppn,
                                                       prot_type prot);
      map_outcome_type res;
      int unsigned     need;
      int unsigned     spare;
      int unsigned     mid_page;
      int unsigned     leaf_page;
      entry_type       root_pte;
      entry_type       mid_pte;
      res = '{status: MAP_REFUSED, leaf: '0, tables: '0};
      spare = (next_table < POOL_PAGES) ? POOL_PAGES - next_table : 0;
      need = 0;
      mid_page = 0;
      leaf_page = 0;
      root_pte = shadow_tables[slot_of(0, vpn[26:18])];
      if (!root_pte[0]) begin
         need = 2;
      end else begin
         mid_page = pool_page(root_pte);
         if (mid_page >= POOL_PAGES) return res;
         mid_pte = shadow_tables[slot_of(mid_page, vpn[17:9])];
         if (!mid_pte[0]) begin
            need = 1;
         end else begin
            leaf_page = pool_page(mid_pte);
            if (leaf_page >= POOL_PAGES) return res;
         end
      end
      // not enough pages left for the whole walk: nothing is taken
      if (need > spare) return res;
      if (need == 2) begin
         mid_page = take_table();
         shadow_tables[slot_of(0, vpn[26:18])] = pointer_to(mid_page);
      end
      if (need >= 1) begin
         leaf_page = take_table();
         shadow_tables[slot_of(mid_page, vpn[17:9])] = pointer_to(leaf_page);
      end
      res.status = MAP_DONE;
      res.leaf   = {ppn, 10'd0} | entry_type'(prot) | entry_type'(LEAF_FLAGS);
      res.tables = new_type'(need);
      // an existing leaf is simply overwritten
      shadow_tables[slot_of(leaf_page, vpn[8:0])] = res.leaf;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // idling: mostly short gaps, a few long ones, and calm stretches with none
   // ---------------------------------------------------------------------
   function automatic int pick_pause(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) calm = $urandom_range(20, 80);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s of response %0d: got 0x%0h, expected 0x%0h",
               what, responses, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // driver: feeds the req channel from the pending queue and predicts each
   // item at the edge where it is taken
   // ---------------------------------------------------------------------
   int              send_gap  = 0;
   int              send_calm = 0;
   map_request_type next_req;
   map_outcome_type outcome;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            outcome = install_mapping(req_virt_page, req_phys_page, req_prot_bits);
            outstanding.push_back(outcome);
            requests_sent++;
            if (outcome.status == MAP_DONE) begin
               installed++;
               tables_taken += int'(outcome.tables);
            end
         end
         // the payload may only move once the current item has gone
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               next_req = pending.pop_front();
               req_valid     <= 1'b1;
               req_virt_page <= next_req.vpn;
               req_phys_page <= next_req.ppn;
               req_prot_bits <= next_req.prot;
               send_gap = pick_pause(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: takes rsp items under random back-pressure and checks them
   // ---------------------------------------------------------------------
   int              hold_left = 0;
   int              hold_calm = 0;
   map_outcome_type due;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (outstanding.size() == 0) begin
               report_mismatch("presence (nothing outstanding)", 64'(rsp_status), '0);
            end else begin
               due = outstanding.pop_front();
               if (rsp_status !== due.status)
                  report_mismatch("status", 64'(rsp_status), 64'(due.status));
               if (rsp_leaf_entry !== due.leaf)
                  report_mismatch("leaf entry", 64'(rsp_leaf_entry), 64'(due.leaf));
               if (rsp_new_tables !== due.tables)
                  report_mismatch("new tables", 64'(rsp_new_tables), 64'(due.tables));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            hold_left = pick_pause(hold_calm);
         end
      end
   end

   // watchdog: any handshake counts as progress
   logic progress;
   int   idle_cycles = 0;

   assign progress = (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                     (csr_valid && csr_ready);

   always @(posedge clock) begin
      if (reset || progress) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("sv39_page_table_mapper test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus planning: rough page budget so that every pool base setting
   // still gets fresh tables, and prefixes already used to go deep
   // ---------------------------------------------------------------------
   bit         roots_planned [int];
   bit         prefixes_planned [int];
   bit         phase_planned [int];
   logic [17:0] all_prefixes [$];
   logic [17:0] phase_prefixes [$];
   int          planned_pages = 0;

   function automatic int table_cost(vpn_type vpn);
      if (!roots_planned.exists(vpn[26:18])) return 2;
      if (!prefixes_planned.exists(vpn[26:9])) return 1;
      return 0;
   endfunction

   function automatic void queue_item(vpn_type vpn, ppn_type ppn, prot_type prot);
      planned_pages += table_cost(vpn);
      roots_planned[vpn[26:18]] = 1'b1;
      if (!prefixes_planned.exists(vpn[26:9])) all_prefixes.push_back(vpn[26:9]);
      prefixes_planned[vpn[26:9]] = 1'b1;
      if (!phase_planned.exists(vpn[26:9])) phase_prefixes.push_back(vpn[26:9]);
      phase_planned[vpn[26:9]] = 1'b1;
      pending.push_back('{vpn: vpn, ppn: ppn, prot: prot});
   endfunction

   function automatic logic [17:0] any_prefix();
      return all_prefixes[$urandom_range(0, all_prefixes.size() - 1)];
   endfunction

   // mostly walks through tables already in use with random leaf index and
   // contents, some new middles under known roots and some fresh roots
   task automatic plan_random(int count, int budget);
      vpn_type     vpn;
      ppn_type     ppn;
      prot_type    prot;
      logic [17:0] pick;
      int          roll;
      int          shape;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         vpn  = vpn_type'($urandom);
         if (roll < 50 && phase_prefixes.size() != 0)
            vpn[26:9] = phase_prefixes[$urandom_range(0, phase_prefixes.size() - 1)];
         else if (roll < 75)
            vpn[26:9] = any_prefix();
         else if (roll < 87) begin
            pick = any_prefix();
            vpn[26:18] = pick[17:9];
         end
         // over budget: stay inside tables that already exist
         if (planned_pages + table_cost(vpn) > budget) vpn[26:9] = any_prefix();
         shape = $urandom_range(0, 15);
         ppn  = (shape == 0) ? '0 : (shape == 1) ? '1 : ppn_type'({$urandom, $urandom});
         prot = (shape == 2) ? '0 : (shape == 3) ? '1 : prot_type'($urandom);
         queue_item(vpn, ppn, prot);
      end
   endtask

   // block idle: nothing left to send, nothing in flight
   task automatic settle();
      do @(posedge clock);
      while (pending.size() != 0 || req_valid || outstanding.size() != 0);
   endtask

   // rewrite the pool base while idle and open a new phase
   task automatic start_phase(ppn_type base);
      csr_valid <= 1'b1;
      csr_data  <= base;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      pool_base = base;
      base_settings++;
      phase_planned.delete();
      phase_prefixes.delete();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset pool base: corners of every field, overwrite, new middle
      queue_item(27'h0000000, 44'h000_0000_0000, 8'h00);    // two fresh tables
      queue_item(27'h7ffffff, 44'hfff_ffff_ffff, 8'hff);    // top of every field
      queue_item(27'h0000000, 44'h000_0000_0123, 8'h20);    // existing leaf overwritten
      queue_item({9'h000, 9'h1ff, 9'h000}, 44'h555_5555_5555, 8'haa);  // new middle only
      queue_item({9'h1ff, 9'h1ff, 9'h000}, 44'haaa_aaaa_aaaa, 8'h55);  // whole walk exists
      queue_item({9'h000, 9'h000, 9'h1ff}, 44'h800_0000_0000, 8'hdf);  // prot equal to flags
      queue_item(27'h2aaaaaa, 44'h000_0000_0001, 8'h01);
      plan_random(240, 9);
      settle();

      // highest base: old pointers fall outside, new ones wrap past 2^44
      start_phase(BASE_HIGHEST);
      queue_item(27'h0000000, 44'h000_0000_0001, 8'h00);    // pointer outside pool
      queue_item({9'h0f0, 9'h000, 9'h000}, 44'h123_4567_89ab, 8'h10);
      queue_item({9'h0f0, 9'h000, 9'h001}, 44'hedc_ba98_7654, 8'h80);
      plan_random(150, 12);
      settle();

      // base zero: wrapped pointers now resolve one page lower
      start_phase(BASE_LOWEST);
      queue_item(27'h0000000, 44'h000_0000_0002, 8'h00);
      queue_item({9'h0f0, 9'h000, 9'h002}, 44'h0f0_f0f0_f0f0, 8'h0f);
      queue_item({9'h00f, 9'h100, 9'h080}, 44'hf0f_0f0f_0f0f, 8'hf0);
      plan_random(150, 15);
      settle();

      // back to the reset base: earlier tables come alive again, then the
      // pool runs dry
      start_phase(POOL_BASE_RESET);
      queue_item(27'h0000000, 44'h000_0000_0003, 8'h02);
      plan_random(200, POOL_PAGES * 4);
      settle();

      // let any stray response show up
      repeat (20) @(posedge clock);
      $display("%0d mapping requests over %0d pool base settings, %0d responses checked",
               requests_sent, base_settings, responses);
      $display("%0d installed, %0d refused, %0d table pages taken out of %0d",
               installed, requests_sent - installed, tables_taken, POOL_PAGES - 1);
      if (mismatches == 0) begin
         $display("sv39_page_table_mapper test passed");
      end else begin
         $display("sv39_page_table_mapper test failed");
      end
      $finish;
   end

endmodule
